// File: rtl/trd_pkg.sv
// Package for the triangle residual distribution block.
// Holds shared types, pipeline constants and fixed-point helpers; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

  localparam int QW         = 32;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QW / DIV_BITS;
  localparam int TRD_LAT    = 2 * DIV_STAGES + 14;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [1:0] {
    KIND_N   = 2'd0,
    KIND_LDA = 2'd1,
    KIND_LIM = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       degen;
    logic       in_neg;
    logic       in_ovf;
    logic       out_neg;
    logic       out_ovf;
    q_t [2:0]   u;
    q_t [2:0]   kp;
  } side1_t;

  typedef struct packed {
    kind_e      kind;
    logic       degen;
    logic       fi_zero;
    logic       fi_neg;
    q_t [2:0]   d;
  } side2_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [32:0] den;
  } div_st_t;

  // magnitude plus sign back to a saturated 32-bit value
  function automatic q_t sat_mag(logic neg, logic [63:0] m);
    logic [63:0] c;
    c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
    if (neg) begin
      return q_t'(32'd0 - c[31:0]);
    end
    return c[31] ? q_t'(32'h7fff_ffff) : q_t'(c[31:0]);
  endfunction

  function automatic q_t sat34(logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return q_t'(32'h7fff_ffff);
    end
    if (v < -34'sd2147483648) begin
      return q_t'(32'h8000_0000);
    end
    return q_t'(v[31:0]);
  endfunction

  function automatic logic signed [63:0] mul32s(q_t a, q_t b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [63:0] mul32u(logic [31:0] a, logic [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Q16.16 product rounding, nearest with ties away from zero
  function automatic q_t fmul_round(logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? (64'd0 - $unsigned(p)) : $unsigned(p);
    m = (m + 64'h8000) >> 16;
    return sat_mag(p[63], m);
  endfunction

endpackage

`default_nettype wire

// File: rtl/trd_div.sv
// Pipelined restoring divider, two quotient bits per stage.
// Requires num_i[63:32] < den_i; uses trd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        vld_o,
  output logic [31:0] quo_o
);
  import trd_pkg::*;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t     r;
    logic [33:0] t;
    r = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      t     = {r.rem, r.low[QW-1]};
      r.low = {r.low[QW-2:0], 1'b0};
      if (t >= {1'b0, r.den}) begin
        t     = t - {1'b0, r.den};
        r.quo = {r.quo[QW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QW-2:0], 1'b0};
      end
      r.rem = t[32:0];
    end
    return r;
  endfunction

  div_st_t                 init;
  div_st_t                 st_d [DIV_STAGES];
  div_st_t                 st_q [DIV_STAGES];
  logic [DIV_STAGES-1:0]   vld_q;

  always_comb begin
    init.rem = {1'b0, num_i[63:32]};
    init.low = num_i[31:0];
    init.quo = '0;
    init.den = den_i;
    st_d[0]  = div_step(init);
    for (int j = 1; j < DIV_STAGES; j++) begin
      st_d[j] = div_step(st_q[j-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[DIV_STAGES-1];
  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// File: rtl/trd_flux.sv
// Front pipeline: edge normals, inflow coefficients k, S, P and Q, division operands.
// Six register stages; uses trd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trd_flux (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  trd_pkg::kind_e        kind_i,
  input  trd_pkg::q_t [2:0]     x_i,
  input  trd_pkg::q_t [2:0]     y_i,
  input  trd_pkg::q_t [2:0]     u_i,
  input  trd_pkg::q_t           adv_x_i,
  input  trd_pkg::q_t           adv_y_i,
  output logic                  vld_o,
  output trd_pkg::side1_t       side_o,
  output logic [63:0]           num_in_o,
  output logic [63:0]           num_out_o,
  output logic [32:0]           den_o
);
  import trd_pkg::*;

  function automatic logic [1:0] nxt(int i);
    return (i == 2) ? 2'd0 : 2'(i + 1);
  endfunction

  function automatic logic [1:0] prv(int i);
    return (i == 0) ? 2'd2 : 2'(i - 1);
  endfunction

  logic [5:0]              vld_q;

  q_t [2:0]                a_nx_d, a_ny_d, a_nx_q, a_ny_q, a_u_q;
  q_t                      a_ax_q, a_ay_q;
  kind_e                   a_kind_q;

  logic signed [63:0]      b_px_d [3];
  logic signed [63:0]      b_py_d [3];
  logic signed [63:0]      b_px_q [3];
  logic signed [63:0]      b_py_q [3];
  q_t [2:0]                b_u_q;
  kind_e                   b_kind_q;

  logic signed [64:0]      c_sum [3];
  logic [64:0]             c_mag [3];
  q_t [2:0]                c_k_d, c_k_q, c_u_q;
  kind_e                   c_kind_q;

  q_t [2:0]                d_kp_d, d_kn_d, d_kp_q, d_u_q;
  logic [32:0]             d_s_d, d_s_q;
  logic signed [63:0]      d_pp_d [3];
  logic signed [63:0]      d_pn_d [3];
  logic signed [63:0]      d_pp_q [3];
  logic signed [63:0]      d_pn_q [3];
  kind_e                   d_kind_q;

  logic signed [33:0]      e_p_d, e_q_d, e_p_q, e_q_q;
  logic [32:0]             e_s_q;
  q_t [2:0]                e_kp_q, e_u_q;
  kind_e                   e_kind_q;

  logic [33:0]             f_mp, f_mq;
  logic [63:0]             f_nin, f_nout;
  side1_t                  f_side_d, f_side_q;
  logic [63:0]             f_num_in_d, f_num_out_d, f_num_in_q, f_num_out_q;
  logic [32:0]             f_den_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nx_d[i] = sat34(34'(y_i[nxt(i)]) - 34'(y_i[prv(i)]));
      a_ny_d[i] = sat34(34'(x_i[prv(i)]) - 34'(x_i[nxt(i)]));
      b_px_d[i] = mul32s(a_ax_q, a_nx_q[i]);
      b_py_d[i] = mul32s(a_ay_q, a_ny_q[i]);
      c_sum[i]  = 65'(b_px_q[i]) + 65'(b_py_q[i]);
      c_mag[i]  = c_sum[i][64] ? (65'd0 - $unsigned(c_sum[i])) : $unsigned(c_sum[i]);
      c_k_d[i]  = sat_mag(c_sum[i][64], (c_mag[i][63:0] + 64'h1_0000) >> 17);
      d_kp_d[i] = c_k_q[i][31] ? q_t'(0) : c_k_q[i];
      d_kn_d[i] = c_k_q[i][31] ? c_k_q[i] : q_t'(0);
      d_pp_d[i] = mul32s(d_kp_d[i], c_u_q[i]);
      d_pn_d[i] = mul32s(d_kn_d[i], c_u_q[i]);
    end
    d_s_d = {1'b0, d_kp_d[0]} + {1'b0, d_kp_d[1]} + {1'b0, d_kp_d[2]};
    e_p_d = 34'(fmul_round(d_pn_q[0])) + 34'(fmul_round(d_pn_q[1]))
          + 34'(fmul_round(d_pn_q[2]));
    e_q_d = 34'(fmul_round(d_pp_q[0])) + 34'(fmul_round(d_pp_q[1]))
          + 34'(fmul_round(d_pp_q[2]));

    // inflow divides -P, outflow divides Q, both scaled by 2^16
    f_mp   = e_p_q[33] ? (34'd0 - $unsigned(e_p_q)) : $unsigned(e_p_q);
    f_mq   = e_q_q[33] ? (34'd0 - $unsigned(e_q_q)) : $unsigned(e_q_q);
    f_nin  = 64'({f_mp[32:0], 16'd0}) + 64'(e_s_q[32:1]);
    f_nout = 64'({f_mq[32:0], 16'd0}) + 64'(e_s_q[32:1]);
    f_side_d.kind    = e_kind_q;
    f_side_d.degen   = (e_s_q == '0);
    f_side_d.in_neg  = ~e_p_q[33] & (|e_p_q);
    f_side_d.in_ovf  = ({1'b0, f_nin[63:32]} >= e_s_q);
    f_side_d.out_neg = e_q_q[33];
    f_side_d.out_ovf = ({1'b0, f_nout[63:32]} >= e_s_q);
    f_side_d.u       = e_u_q;
    f_side_d.kp      = e_kp_q;
    f_num_in_d  = f_side_d.in_ovf ? '0 : f_nin;
    f_num_out_d = f_side_d.out_ovf ? '0 : f_nout;
  end

  always_ff @(posedge clk_i) begin
    a_nx_q      <= a_nx_d;
    a_ny_q      <= a_ny_d;
    a_ax_q      <= adv_x_i;
    a_ay_q      <= adv_y_i;
    a_u_q       <= u_i;
    a_kind_q    <= kind_i;
    b_px_q      <= b_px_d;
    b_py_q      <= b_py_d;
    b_u_q       <= a_u_q;
    b_kind_q    <= a_kind_q;
    c_k_q       <= c_k_d;
    c_u_q       <= b_u_q;
    c_kind_q    <= b_kind_q;
    d_kp_q      <= d_kp_d;
    d_s_q       <= d_s_d;
    d_pp_q      <= d_pp_d;
    d_pn_q      <= d_pn_d;
    d_u_q       <= c_u_q;
    d_kind_q    <= c_kind_q;
    e_p_q       <= e_p_d;
    e_q_q       <= e_q_d;
    e_s_q       <= d_s_q;
    e_kp_q      <= d_kp_q;
    e_u_q       <= d_u_q;
    e_kind_q    <= d_kind_q;
    f_side_q    <= f_side_d;
    f_num_in_q  <= f_num_in_d;
    f_num_out_q <= f_num_out_d;
    f_den_q     <= e_s_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  assign vld_o     = vld_q[5];
  assign side_o    = f_side_q;
  assign num_in_o  = f_num_in_q;
  assign num_out_o = f_num_out_q;
  assign den_o     = f_den_q;

endmodule

`default_nettype wire

// File: rtl/trd_share.sv
// Middle pipeline: inflow/outflow states, N and LDA shares, limiter weights.
// Seven register stages; uses trd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trd_share (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [31:0]           q_in_i,
  input  logic [31:0]           q_out_i,
  input  trd_pkg::side1_t       side_i,
  output logic                  vld_o,
  output trd_pkg::side2_t       side_o,
  output logic [63:0]           num_o [3],
  output logic [32:0]           den_o
);
  import trd_pkg::*;

  logic [6:0]          vld_q;

  q_t                  h_in, h_out;
  q_t                  h_diff_d, h_diff_q;
  q_t [2:0]            h_t_d, h_t_q, h_kp_q;
  kind_e               h_kind_q;
  logic                h_degen_q;

  logic signed [63:0]  i_m_d [3];
  logic signed [63:0]  i_m_q [3];
  kind_e               i_kind_q;
  logic                i_degen_q;

  q_t [2:0]            j_d_d, j_d_q;
  kind_e               j_kind_q;
  logic                j_degen_q;

  q_t                  k_fi_d, k_fi_q;
  q_t [2:0]            k_d_q;
  kind_e               k_kind_q;
  logic                k_degen_q;

  logic signed [33:0]  l_sd [3];
  logic [31:0]         l_afi_d, l_afi_q;
  logic [31:0]         l_bp_d [3];
  logic [31:0]         l_bp_q [3];
  logic [32:0]         l_bsum_d, l_bsum_q;
  side2_t              l_side_d, l_side_q;

  logic [63:0]         m_prod_d [3];
  logic [63:0]         m_prod_q [3];
  logic [32:0]         m_bsum_q;
  side2_t              m_side_q;

  logic [63:0]         n_num_d [3];
  logic [63:0]         n_num_q [3];
  logic [32:0]         n_bsum_q;
  side2_t              n_side_q;

  always_comb begin
    h_in     = sat_mag(side_i.in_neg, side_i.in_ovf ? 64'h1_0000_0000 : 64'(q_in_i));
    h_out    = sat_mag(side_i.out_neg, side_i.out_ovf ? 64'h1_0000_0000 : 64'(q_out_i));
    h_diff_d = sat34(34'(h_out) - 34'(h_in));
    for (int i = 0; i < 3; i++) begin
      h_t_d[i] = sat34(34'(side_i.u[i]) - 34'(h_in));
      i_m_d[i] = mul32s(h_kp_q[i], (h_kind_q == KIND_LDA) ? h_diff_q : h_t_q[i]);
      j_d_d[i] = fmul_round(i_m_q[i]);
    end
    k_fi_d  = sat34(34'(j_d_q[0]) + 34'(j_d_q[1]) + 34'(j_d_q[2]));

    // limiter weights: b_i = max(0, sign(fi) * d_i) + 1 lsb
    l_afi_d = k_fi_q[31] ? (32'd0 - $unsigned(k_fi_q)) : $unsigned(k_fi_q);
    for (int i = 0; i < 3; i++) begin
      l_sd[i] = k_fi_q[31] ? (34'sd0 - 34'(k_d_q[i])) : 34'(k_d_q[i]);
      l_bp_d[i] = (l_sd[i] > 34'sd0) ? (l_sd[i][31:0] + 32'd1) : 32'd1;
      m_prod_d[i] = mul32u(l_afi_q, l_bp_q[i]);
      n_num_d[i]  = m_prod_q[i] + 64'(m_bsum_q[32:1]);
    end
    l_bsum_d = 33'(l_bp_d[0]) + 33'(l_bp_d[1]) + 33'(l_bp_d[2]);
    l_side_d.kind    = k_kind_q;
    l_side_d.degen   = k_degen_q;
    l_side_d.fi_zero = (k_fi_q == '0);
    l_side_d.fi_neg  = k_fi_q[31];
    l_side_d.d       = k_d_q;
  end

  always_ff @(posedge clk_i) begin
    h_diff_q  <= h_diff_d;
    h_t_q     <= h_t_d;
    h_kp_q    <= side_i.kp;
    h_kind_q  <= side_i.kind;
    h_degen_q <= side_i.degen;
    i_m_q     <= i_m_d;
    i_kind_q  <= h_kind_q;
    i_degen_q <= h_degen_q;
    j_d_q     <= j_d_d;
    j_kind_q  <= i_kind_q;
    j_degen_q <= i_degen_q;
    k_fi_q    <= k_fi_d;
    k_d_q     <= j_d_q;
    k_kind_q  <= j_kind_q;
    k_degen_q <= j_degen_q;
    l_afi_q   <= l_afi_d;
    l_bp_q    <= l_bp_d;
    l_bsum_q  <= l_bsum_d;
    l_side_q  <= l_side_d;
    m_prod_q  <= m_prod_d;
    m_bsum_q  <= l_bsum_q;
    m_side_q  <= l_side_q;
    n_num_q   <= n_num_d;
    n_bsum_q  <= m_bsum_q;
    n_side_q  <= m_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  assign vld_o  = vld_q[6];
  assign side_o = n_side_q;
  assign num_o  = n_num_q;
  assign den_o  = n_bsum_q;

endmodule

`default_nettype wire

// File: rtl/triangle_residual_distribution.sv
// Top level of the triangle residual distribution block (N, LDA, limited N).
// Uses trd_pkg, trd_flux, trd_div and trd_share.
//
// Usage:
//   An item (one triangle: vertices, advection vector, nodal values, kind) is
//   taken at a rising edge where start is high and busy is low. busy stays
//   low, so a new item may enter on every cycle.
//   Each item gives one result: share0_o..share2_o and degenerate_o, shown
//   for exactly one cycle with valid_o high, once the item has passed all
//   pipeline stages listed below.
//   Results leave in the order the items came in.
//   Throughput is one item per cycle. Latency is set by six front stages,
//   two ranks of 16-stage dividers (two quotient bits per stage; first a
//   pair for the inflow/outflow states, then three for the limiter),
//   seven middle stages and the output register.
//   The receiver cannot hold results off; the pipeline never stalls.
//   Reset (rst_ni low, asynchronous) clears all valid bits; items in flight
//   are dropped and no result is shown until new items pass through.
`timescale 1ns / 1ps
`default_nettype none

module triangle_residual_distribution (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] x0_i,
  input  logic signed [31:0] y0_i,
  input  logic signed [31:0] x1_i,
  input  logic signed [31:0] y1_i,
  input  logic signed [31:0] x2_i,
  input  logic signed [31:0] y2_i,
  input  logic signed [31:0] adv_x_i,
  input  logic signed [31:0] adv_y_i,
  input  logic signed [31:0] u0_i,
  input  logic signed [31:0] u1_i,
  input  logic signed [31:0] u2_i,
  output logic               valid_o,
  output logic signed [31:0] share0_o,
  output logic signed [31:0] share1_o,
  output logic signed [31:0] share2_o,
  output logic               degenerate_o
);
  import trd_pkg::*;

  logic                  accept;
  q_t [2:0]              xs, ys, us;

  logic                  flux_vld;
  side1_t                flux_side;
  logic [63:0]           num_in, num_out;
  logic [32:0]           den_flow;

  logic                  div_in_vld, div_out_vld;
  logic [31:0]           q_in, q_out;

  side1_t                l1_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] l1_vld_q;

  logic                  sh_vld;
  side2_t                sh_side;
  logic [63:0]           sh_num [3];
  logic [32:0]           sh_den;

  logic [2:0]            lim_vld;
  logic [31:0]           lim_q [3];

  side2_t                l2_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] l2_vld_q;

  side2_t                fin;
  q_t [2:0]              share_d, share_q;
  logic                  degen_q, valid_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign xs     = {x2_i, x1_i, x0_i};
  assign ys     = {y2_i, y1_i, y0_i};
  assign us     = {u2_i, u1_i, u0_i};

  trd_flux u_flux (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (accept),
    .kind_i    (kind_e'(kind_i)),
    .x_i       (xs),
    .y_i       (ys),
    .u_i       (us),
    .adv_x_i   (adv_x_i),
    .adv_y_i   (adv_y_i),
    .vld_o     (flux_vld),
    .side_o    (flux_side),
    .num_in_o  (num_in),
    .num_out_o (num_out),
    .den_o     (den_flow)
  );

  trd_div u_div_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (flux_vld),
    .num_i  (num_in),
    .den_i  (den_flow),
    .vld_o  (div_in_vld),
    .quo_o  (q_in)
  );

  trd_div u_div_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (flux_vld),
    .num_i  (num_out),
    .den_i  (den_flow),
    .vld_o  (div_out_vld),
    .quo_o  (q_out)
  );

  always_ff @(posedge clk_i) begin
    l1_q[0] <= flux_side;
    l2_q[0] <= sh_side;
    for (int j = 1; j < DIV_STAGES; j++) begin
      l1_q[j] <= l1_q[j-1];
      l2_q[j] <= l2_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_vld_q <= '0;
      l2_vld_q <= '0;
    end else begin
      l1_vld_q <= {l1_vld_q[DIV_STAGES-2:0], flux_vld};
      l2_vld_q <= {l2_vld_q[DIV_STAGES-2:0], sh_vld};
    end
  end

  trd_share u_share (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (div_in_vld),
    .q_in_i  (q_in),
    .q_out_i (q_out),
    .side_i  (l1_q[DIV_STAGES-1]),
    .vld_o   (sh_vld),
    .side_o  (sh_side),
    .num_o   (sh_num),
    .den_o   (sh_den)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lim
    trd_div u_div_lim (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sh_vld),
      .num_i  (sh_num[g]),
      .den_i  (sh_den),
      .vld_o  (lim_vld[g]),
      .quo_o  (lim_q[g])
    );
  end

  assign fin = l2_q[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      share_d[i] = '0;
      if (!fin.degen) begin
        case (fin.kind)
          KIND_N, KIND_LDA: share_d[i] = fin.d[i];
          KIND_LIM: begin
            if (!fin.fi_zero) begin
              share_d[i] = sat_mag(fin.fi_neg, 64'(lim_q[i]));
            end
          end
          default: share_d[i] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    share_q <= share_d;
    degen_q <= fin.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lim_vld[0];
    end
  end

  assign valid_o      = valid_q;
  assign share0_o     = share_q[0];
  assign share1_o     = share_q[1];
  assign share2_o     = share_q[2];
  assign degenerate_o = degen_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> share0_o == '0 && share1_o == '0 && share2_o == '0)
    else $error("degenerate item with nonzero share");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, TRD_LAT))
    else $error("result without matching item");

  a_flow_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_in_vld == l1_vld_q[DIV_STAGES-1] && div_out_vld == div_in_vld)
    else $error("flow divider out of step with side data");

  a_lim_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim_vld[0] == l2_vld_q[DIV_STAGES-1] && lim_vld[1] == lim_vld[0]
    && lim_vld[2] == lim_vld[0])
    else $error("limiter divider out of step with side data");

endmodule

`default_nettype wire
